@@ src/rqbv_pkg.sv @@
`default_nettype none
package rqbv_pkg;

  localparam int REPLICA_COUNT = 6;
  localparam int SLOT_W        = 64;
  localparam int ID_W          = 3;
  localparam int FAULT_W       = 4;
  localparam int INTERVAL_W    = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CNT_W         = 3;
  localparam int TAB_ADDR_W    = ID_W + 1;
  localparam int TAB_DEPTH     = 2 ** TAB_ADDR_W;

  localparam logic [ID_W-1:0] ID_FIRST    = ID_W'(1);
  localparam logic [ID_W-1:0] ID_LAST     = ID_W'(REPLICA_COUNT);
  localparam logic [ID_W-1:0] ANCHOR_LAST = ID_W'(REPLICA_COUNT - 1);

  localparam logic CFG_FAULT_BOUND   = 1'b0;
  localparam logic CFG_SLOT_INTERVAL = 1'b1;

  localparam logic [FAULT_W-1:0]    FAULT_BOUND_RESET   = FAULT_W'(1);
  localparam logic [INTERVAL_W-1:0] SLOT_INTERVAL_RESET = INTERVAL_W'(1000);

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_TRIP   = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ANCHOR,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic take_report;
    logic ack;
    logic store;
    logic anchor_load;
    logic anchor_next;
    logic scan_step;
    logic quorum;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_report;
    logic report_differs;
    logic drop;
    logic ack_now;
    logic anchor_empty;
    logic anchor_last;
    logic scan_last;
    logic quorum_hit;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ src/rqbv_ctrl.sv @@
`default_nettype none
module rqbv_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rqbv_pkg::dp_status_t status,
  output rqbv_pkg::dp_cmd_t        cmd
);
  import rqbv_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.is_report) begin
          state_next = status.report_differs ? ST_EMIT : ST_IDLE;
        end else if (status.drop) begin
          state_next = ST_IDLE;
        end else if (status.ack_now) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_ANCHOR;
        end
      end
      ST_ANCHOR: begin
        if (status.anchor_empty) begin
          state_next = status.anchor_last ? ST_IDLE : ST_ANCHOR;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.quorum_hit) begin
          state_next = ST_EMIT;
        end else if (status.scan_last) begin
          state_next = status.anchor_last ? ST_IDLE : ST_ANCHOR;
        end
      end
      ST_EMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CHECK: begin
        if (status.is_report) begin
          cmd.take_report = status.report_differs;
        end else if (!status.drop) begin
          cmd.ack   = status.ack_now;
          cmd.store = !status.ack_now;
        end
      end
      ST_ANCHOR: begin
        cmd.anchor_load = !status.anchor_empty;
        cmd.anchor_next = status.anchor_empty && !status.anchor_last;
      end
      ST_SCAN: begin
        cmd.scan_step   = 1'b1;
        cmd.quorum      = status.quorum_hit;
        cmd.anchor_next = !status.quorum_hit && status.scan_last && !status.anchor_last;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/rqbv_datapath.sv @@
`default_nettype none
module rqbv_datapath (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     cfg_we,
  input  wire logic                                     cfg_index,
  input  wire logic [rqbv_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  wire logic [1:0]                               command,
  input  wire logic [rqbv_pkg::ID_W-1:0]                replica_id,
  input  wire logic [rqbv_pkg::SLOT_W-1:0]              msg_slot,
  input  wire logic [rqbv_pkg::SLOT_W-1:0]              now_slot,
  input  wire logic                                     authentic,
  input  wire logic                                     reported_trip,
  input  wire rqbv_pkg::dp_cmd_t                        cmd,
  output rqbv_pkg::dp_status_t                          status,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic                                          ack_trip,
  output logic [rqbv_pkg::SLOT_W-1:0]                   ack_slot,
  output logic                                          ack_source
);
  import rqbv_pkg::*;

  logic [FAULT_W-1:0]    fault_bound;
  logic [INTERVAL_W-1:0] slot_interval;
  logic                  breaker;
  logic [SLOT_W-1:0]     last_ack;
  logic                  feedback;

  cmd_t              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [SLOT_W-1:0] mslot_q;
  logic [SLOT_W-1:0] now_q;
  logic              auth_q;
  logic              rtrip_q;
  logic [SLOT_W:0]   now_plus_q;

  logic [SLOT_W-1:0] tab_data [TAB_DEPTH];
  logic [TAB_DEPTH-1:0] tab_valid;

  logic [ID_W-1:0]   anchor_idx;
  logic [ID_W-1:0]   scan_idx;
  logic              scanning;
  logic [CNT_W-1:0]  lo_cnt;
  logic [CNT_W-1:0]  hi_cnt;
  logic [SLOT_W-1:0] anchor_v;
  logic [SLOT_W-1:0] anchor_lo;
  logic [SLOT_W-1:0] anchor_hi;
  logic              anchor_lo_ok;
  logic              anchor_hi_ok;

  logic                  want;
  logic [ID_W-1:0]       rd_idx;
  logic [TAB_ADDR_W-1:0] rd_addr;
  logic [TAB_ADDR_W-1:0] wr_addr;
  logic [SLOT_W-1:0]     rd;
  logic [SLOT_W-1:0]     interval_ext;
  logic [SLOT_W:0]       rd_plus;
  logic                  match_lo;
  logic                  match_hi;
  logic [CNT_W-1:0]      lo_next;
  logic [CNT_W-1:0]      hi_next;
  logic [FAULT_W-1:0]    need;
  logic                  id_ok;

  assign want         = (cmd_q == CMD_TRIP);
  assign rd_idx       = scanning ? scan_idx : anchor_idx;
  assign rd_addr      = {want, rd_idx};
  assign wr_addr      = {want, id_q};
  assign rd           = tab_valid[rd_addr] ? tab_data[rd_addr] : '0;
  assign interval_ext = SLOT_W'(slot_interval);
  assign rd_plus      = {1'b0, rd} + {1'b0, interval_ext};
  assign need         = (fault_bound == '0) ? FAULT_W'(1) : fault_bound;
  assign id_ok        = (id_q >= ID_FIRST) && (id_q <= ID_LAST);

  assign match_lo = (rd != '0) && ((rd == anchor_v) || (anchor_lo_ok && rd == anchor_lo));
  assign match_hi = (rd != '0) && ((rd == anchor_v) || (anchor_hi_ok && rd == anchor_hi));
  assign lo_next  = lo_cnt + CNT_W'(match_lo);
  assign hi_next  = hi_cnt + CNT_W'(match_hi);

  always_comb begin
    status                = '0;
    status.is_report      = (cmd_q == CMD_REPORT);
    status.report_differs = (rtrip_q != breaker);
    status.drop           = !id_ok || !auth_q || (mslot_q < last_ack)
                            || ({1'b0, mslot_q} > now_plus_q);
    status.ack_now        = (cmd_q == CMD_QUERY) || (breaker == want);
    status.anchor_empty   = (rd == '0);
    status.anchor_last    = (anchor_idx == ANCHOR_LAST);
    status.scan_last      = (scan_idx == ID_LAST);
    status.quorum_hit     = (FAULT_W'(lo_next) >= need) || (FAULT_W'(hi_next) >= need);
    status.out_free       = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_bound   <= FAULT_BOUND_RESET;
      slot_interval <= SLOT_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAULT_BOUND:   fault_bound   <= cfg_data[FAULT_W-1:0];
        CFG_SLOT_INTERVAL: slot_interval <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q      <= cmd_t'(command);
      id_q       <= replica_id;
      mslot_q    <= msg_slot;
      now_q      <= now_slot;
      auth_q     <= authentic;
      rtrip_q    <= reported_trip;
      now_plus_q <= {1'b0, now_slot} + {1'b0, interval_ext};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      breaker  <= 1'b0;
      last_ack <= '0;
      feedback <= 1'b0;
    end else if (cmd.take_report) begin
      breaker  <= rtrip_q;
      feedback <= 1'b1;
    end else if (cmd.ack) begin
      last_ack <= now_q;
      feedback <= 1'b0;
    end else if (cmd.quorum) begin
      breaker  <= want;
      last_ack <= now_q;
      feedback <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) tab_data[wr_addr] <= mslot_q;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.quorum) begin
      tab_valid <= '0;
    end else if (cmd.store) begin
      tab_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      anchor_idx <= ID_FIRST;
    end else if (cmd.anchor_next) begin
      anchor_idx <= anchor_idx + ID_W'(1);
    end
    if (cmd.anchor_load) begin
      scan_idx     <= anchor_idx + ID_W'(1);
      lo_cnt       <= '0;
      hi_cnt       <= '0;
      anchor_v     <= rd;
      anchor_lo    <= rd - interval_ext;
      anchor_lo_ok <= (rd >= interval_ext);
      anchor_hi    <= rd_plus[SLOT_W-1:0];
      anchor_hi_ok <= !rd_plus[SLOT_W];
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + ID_W'(1);
      lo_cnt   <= lo_next;
      hi_cnt   <= hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
    end else if (cmd.anchor_load) begin
      scanning <= 1'b1;
    end else if (cmd.scan_step && (status.quorum_hit || status.scan_last)) begin
      scanning <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ack_trip   <= breaker;
      ack_slot   <= last_ack;
      ack_source <= feedback;
    end
  end

endmodule
`default_nettype wire

@@ src/replica_quorum_breaker_voter_top.sv @@
// Breaker voter for replicated relays.
// Input channel (in_valid/in_ready) carries one item per transfer: a recovery
// query, a trip vote, a close vote or a breaker state report. Output channel
// (out_valid/out_ready) carries at most one acknowledgement per item.
// Configuration: cfg_we writes cfg_data into fault_bound (index 0) or
// slot_interval (index 1) in the same cycle; write only while idle.
// Flow: the item is checked in the cycle after its transfer; a query, a
// re-acknowledged vote or a differing state report then goes from the check
// step to the emit step, which loads the output register. A stored vote runs
// a pairwise scan of the replica table, one anchor load or one compare per
// cycle, each filled anchor against every later replica, until a quorum is
// found or the last anchor is done. One item is in work at a time; in_ready
// rises again when its work is done.
// The result sits in an output register: a new item is taken while it waits,
// and the block holds in its emit step only if a second result is due before
// the first has been taken.
// Reset (rst, synchronous) closes the breaker, zeroes the last acknowledged
// slot, empties both vote tables, restores the registers and drops any
// pending result.
`default_nettype none
module replica_quorum_breaker_voter_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [rqbv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          command,
  input  wire logic [rqbv_pkg::ID_W-1:0]           replica_id,
  input  wire logic [rqbv_pkg::SLOT_W-1:0]         msg_slot,
  input  wire logic [rqbv_pkg::SLOT_W-1:0]         now_slot,
  input  wire logic                                authentic,
  input  wire logic                                reported_trip,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     ack_trip,
  output logic [rqbv_pkg::SLOT_W-1:0]              ack_slot,
  output logic                                     ack_source
);
  import rqbv_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  rqbv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  rqbv_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .replica_id    (replica_id),
    .msg_slot      (msg_slot),
    .now_slot      (now_slot),
    .authentic     (authentic),
    .reported_trip (reported_trip),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ack_trip      (ack_trip),
    .ack_slot      (ack_slot),
    .ack_source    (ack_source)
  );

endmodule
`default_nettype wire

@@ src/rqbv_checker.sv @@
`default_nettype none
module rqbv_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          ack_trip,
  input wire logic [rqbv_pkg::SLOT_W-1:0]   ack_slot,
  input wire logic                          ack_source
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ack_trip) && $stable(ack_slot)
                                && $stable(ack_source))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input transfer while item in work");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in work");

endmodule

bind replica_quorum_breaker_voter_top rqbv_checker u_rqbv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .ack_trip   (ack_trip),
  .ack_slot   (ack_slot),
  .ack_source (ack_source)
);
`default_nettype wire

@@ tb/sv/tb_replica_quorum_breaker_voter_top.sv @@
`default_nettype none
module tb_replica_quorum_breaker_voter_top;
  import rqbv_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 140;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] mslot;
    logic [SLOT_W-1:0] now;
    logic              auth;
    logic              rtrip;
  } vote_item_t;

  typedef struct packed {
    logic              trip;
    logic [SLOT_W-1:0] slot;
    logic              source;
  } ack_t;

  class breaker_ledger;
    logic [FAULT_W-1:0]    fault_bound;
    logic [INTERVAL_W-1:0] slot_interval;
    logic                  tripped;
    logic [SLOT_W-1:0]     last_ack;
    logic [SLOT_W-1:0]     trip_tab [8];
    logic [SLOT_W-1:0]     close_tab [8];
    ack_t                  due_acks [$];
    int                    errors;

    function new();
      errors = 0;
      fault_bound = FAULT_BOUND_RESET;
      slot_interval = SLOT_INTERVAL_RESET;
      tripped = 1'b0;
      last_ack = '0;
      clear_tables();
    endfunction

    function void clear_tables();
      foreach (trip_tab[i]) begin
        trip_tab[i] = '0;
        close_tab[i] = '0;
      end
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FAULT_BOUND) begin
        fault_bound = data[FAULT_W-1:0];
      end else begin
        slot_interval = data[INTERVAL_W-1:0];
      end
    endfunction

    function void push_ack(logic trip, logic [SLOT_W-1:0] slot, logic source);
      ack_t a;
      a.trip = trip;
      a.slot = slot;
      a.source = source;
      due_acks.push_back(a);
    endfunction

    function void ack_vote(logic [SLOT_W-1:0] now);
      last_ack = now;
      push_ack(tripped, now, 1'b0);
    endfunction

    function bit has_quorum(logic for_trip);
      logic [SLOT_W-1:0] tab [8];
      logic [SLOT_W-1:0] v;
      logic [SLOT_W-1:0] w;
      logic [SLOT_W-1:0] d;
      int lo;
      int hi;
      int need;
      if (for_trip) begin
        tab = trip_tab;
      end else begin
        tab = close_tab;
      end
      need = (fault_bound == 0) ? 1 : int'(fault_bound);
      d = SLOT_W'(slot_interval);
      for (int i = 1; i < REPLICA_COUNT; i++) begin
        v = tab[i];
        if (v != 0) begin
          lo = 0;
          hi = 0;
          for (int j = i + 1; j <= REPLICA_COUNT; j++) begin
            w = tab[j];
            if (w != 0) begin
              if (w == v || (v >= d && v - d == w)) lo++;
              if (w == v || (w >= d && w - d == v)) hi++;
              if (lo >= need || hi >= need) return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_item(vote_item_t it);
      logic want;
      if (it.cmd == CMD_REPORT) begin
        if (it.rtrip != tripped) begin
          tripped = it.rtrip;
          push_ack(tripped, last_ack, 1'b1);
        end
        return;
      end
      if (it.id < ID_FIRST || it.id > ID_LAST || !it.auth || it.mslot < last_ack) return;
      if (it.mslot > it.now && it.mslot - it.now > SLOT_W'(slot_interval)) return;
      if (it.cmd == CMD_QUERY) begin
        ack_vote(it.now);
        return;
      end
      want = (it.cmd == CMD_TRIP);
      if (tripped == want) begin
        ack_vote(it.now);
        return;
      end
      if (want) begin
        trip_tab[it.id] = it.mslot;
      end else begin
        close_tab[it.id] = it.mslot;
      end
      if (!has_quorum(want)) return;
      tripped = want;
      clear_tables();
      ack_vote(it.now);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_ack(ack_t got);
      ack_t want;
      if (due_acks.size() == 0) begin
        report($sformatf("unexpected ack trip=%0b slot=%0h source=%0b",
                         got.trip, got.slot, got.source));
        return;
      end
      want = due_acks.pop_front();
      if (got.trip !== want.trip)
        report($sformatf("ack_trip got %0b want %0b", got.trip, want.trip));
      if (got.slot !== want.slot)
        report($sformatf("ack_slot got %0h want %0h", got.slot, want.slot));
      if (got.source !== want.source)
        report($sformatf("ack_source got %0b want %0b", got.source, want.source));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            command = 2'b00;
  logic [ID_W-1:0]       replica_id = '0;
  logic [SLOT_W-1:0]     msg_slot = '0;
  logic [SLOT_W-1:0]     now_slot = '0;
  logic                  authentic = 1'b0;
  logic                  reported_trip = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  ack_trip;
  logic [SLOT_W-1:0]     ack_slot;
  logic                  ack_source;

  breaker_ledger     ledger = new();
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                hold_req = 1'b0;
  logic [SLOT_W-1:0] now_cur = '0;

  int phase_fb [PHASES]   = '{1, 2, 0, 15, 5, 3, 1, 4};
  int phase_iv [PHASES]   = '{1000, 1, 0, 65535, 7, 100, 65535, 2};
  int phase_send [PHASES] = '{0, 59, 0, 23, 0, 59, 0, 23};
  int phase_recv [PHASES] = '{0, 0, 59, 23, 0, 0, 59, 23};

  replica_quorum_breaker_voter_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .replica_id    (replica_id),
    .msg_slot      (msg_slot),
    .now_slot      (now_slot),
    .authentic     (authentic),
    .reported_trip (reported_trip),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ack_trip      (ack_trip),
    .ack_slot      (ack_slot),
    .ack_source    (ack_source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [SLOT_W-1:0] rand_slot();
    return {$urandom, $urandom};
  endfunction

  function automatic vote_item_t pack_item(cmd_t c, int id, logic [SLOT_W-1:0] ms,
                                           logic [SLOT_W-1:0] nw, logic a, logic r);
    vote_item_t it;
    it.cmd = c;
    it.id = ID_W'(id);
    it.mslot = ms;
    it.now = nw;
    it.auth = a;
    it.rtrip = r;
    return it;
  endfunction

  function automatic vote_item_t make_traffic();
    vote_item_t        it;
    int                pick;
    logic              to_trip;
    logic [SLOT_W-1:0] d;
    d = SLOT_W'(ledger.slot_interval);
    if (now_cur < ledger.last_ack) now_cur = ledger.last_ack;
    if ($urandom_range(11) == 0) now_cur += (d == 0) ? 1 : d;
    it.now = now_cur;
    it.mslot = now_cur;
    it.auth = 1'b1;
    it.rtrip = 1'($urandom_range(1));
    it.id = ID_W'($urandom_range(1, REPLICA_COUNT));
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.cmd = CMD_QUERY;
    end else if (pick < 16) begin
      it.cmd = CMD_REPORT;
      it.mslot = rand_slot();
      it.now = rand_slot();
    end else begin
      to_trip = ($urandom_range(4) != 0) ? !ledger.tripped : ledger.tripped;
      it.cmd = to_trip ? CMD_TRIP : CMD_CLOSE;
      case ($urandom_range(9))
        0, 1: it.mslot = (now_cur >= d) ? now_cur - d : now_cur;
        7, 8: it.mslot = now_cur + d;
        9: it.mslot = now_cur + d + 1 + SLOT_W'($urandom_range(1000));
        default: it.mslot = now_cur;
      endcase
    end
    if (it.cmd != CMD_REPORT && $urandom_range(19) == 0) begin
      case ($urandom_range(2))
        0: it.id = '0;
        1: it.id = '1;
        default: it.auth = 1'b0;
      endcase
    end
    return it;
  endfunction

  function automatic vote_item_t make_noise();
    vote_item_t it;
    it.cmd = cmd_t'($urandom_range(3));
    it.id = ID_W'($urandom_range(7));
    it.mslot = rand_slot();
    it.now = rand_slot();
    it.auth = 1'($urandom_range(1));
    it.rtrip = 1'($urandom_range(1));
    if (it.cmd != CMD_REPORT && it.id >= ID_FIRST && it.id <= ID_LAST) it.auth = 1'b0;
    return it;
  endfunction

  task automatic drive_item(vote_item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= it.cmd;
    replica_id <= it.id;
    msg_slot <= it.mslot;
    now_slot <= it.now;
    authentic <= it.auth;
    reported_trip <= it.rtrip;
    do @(posedge clk); while (!in_ready);
    ledger.note_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.due_acks.size() != 0);
  endtask

  task automatic write_regs(int fb, int iv);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FAULT_BOUND;
    cfg_data <= CFG_DATA_W'(($urandom_range(4095) << FAULT_W) | fb);
    @(posedge clk);
    ledger.write_reg(CFG_FAULT_BOUND, cfg_data);
    cfg_index <= CFG_SLOT_INTERVAL;
    cfg_data <= CFG_DATA_W'(iv);
    @(posedge clk);
    ledger.write_reg(CFG_SLOT_INTERVAL, cfg_data);
    cfg_we <= 1'b0;
  endtask

  // receiver: check each transfer, then choose next ready
  initial begin : receiver
    ack_t got;
    int   hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.trip = ack_trip;
        got.slot = ack_slot;
        got.source = ack_source;
        ledger.check_ack(got);
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : main
    vote_item_t it;
    int         counted;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    drive_item(pack_item(CMD_TRIP, 3, 0, 0, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 4, 0, 0, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 5, '1 - 499, '1, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 6, 500, 600, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 4, '1, '1 - 9, 1'b1, 1'b0));
    drive_item(pack_item(CMD_QUERY, 1, 100, 100, 1'b1, 1'b0));
    drive_item(pack_item(CMD_REPORT, 0, rand_slot(), rand_slot(), 1'b0, 1'b0));
    drive_item(pack_item(CMD_REPORT, 7, rand_slot(), rand_slot(), 1'b1, 1'b1));
    drive_item(pack_item(CMD_REPORT, 2, rand_slot(), rand_slot(), 1'b0, 1'b0));
    drive_item(pack_item(CMD_TRIP, 0, 200, 200, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 7, 200, 200, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 1, 200, 200, 1'b0, 1'b0));
    drive_item(pack_item(CMD_TRIP, 1, 99, 200, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 1, 1201, 200, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 1, 1200, 200, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 2, 2200, 2000, 1'b1, 1'b0));
    drive_item(pack_item(CMD_TRIP, 3, 2000, 2000, 1'b1, 1'b0));
    drive_item(pack_item(CMD_CLOSE, 6, 2000, 2100, 1'b1, 1'b0));
    drive_item(pack_item(CMD_CLOSE, 5, 1000, 2100, 1'b1, 1'b0));
    drive_item(pack_item(CMD_CLOSE, 5, 3000, 2100, 1'b1, 1'b0));
    drive_item(pack_item(CMD_CLOSE, 2, 2100, 2100, 1'b1, 1'b0));
    drive_item(pack_item(CMD_REPORT, 1, rand_slot(), rand_slot(), 1'b1, 1'b1));
    drive_item(pack_item(CMD_QUERY, 6, 2100, 2100, 1'b1, 1'b0));

    now_cur = ledger.last_ack + SLOT_W'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      repeat (30) @(posedge clk);
      write_regs(phase_fb[p], phase_iv[p]);
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = ($urandom_range(99) < 15) ? make_noise() : make_traffic();
        drive_item(it);
        if (it.cmd == CMD_REPORT || it.auth) counted++;
        // fill the block against a blocked receiver
        if (p == 0 && counted == 40) hold_req = 1'b1;
        if (p == 2 && counted % 50 == 49) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (ledger.errors == 0 && ledger.due_acks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/rqbv_pkg.sv
src/rqbv_ctrl.sv
src/rqbv_datapath.sv
src/replica_quorum_breaker_voter_top.sv
src/rqbv_checker.sv
tb/sv/tb_replica_quorum_breaker_voter_top.sv
